FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the matrix multiply unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, off during reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never hold on a rising clock edge outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: rtl/imm_pkg.sv
// Types, constants and helper functions of the integer matrix multiply unit.
`timescale 1ns / 1ps
package imm_pkg;

  // Largest matrix dimension held by the element stores
  localparam int MAX_DIM   = 8;
  localparam int DEPTH     = MAX_DIM * MAX_DIM;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Field widths
  localparam int IDX_W     = 3;
  localparam int DATA_W    = 32;
  localparam int MODE_W    = 2;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;

  // Stream word widths, fields packed from bit 0 and padded to whole bytes
  localparam int FIELD_W   = 2 * IDX_W + DATA_W;
  localparam int S_TDATA_W = ((FIELD_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((FIELD_W + 7) / 8) * 8;
  localparam int PAD_W     = M_TDATA_W - FIELD_W;

  // Item kinds carried in tuser
  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE_A = 2'd0,
    MODE_WRITE_B = 2'd1,
    MODE_COMPUTE = 2'd2
  } mode_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS_A    = 2'd0,
    REG_INNER_DIM = 2'd1,
    REG_COLS_B    = 2'd2
  } cfg_reg_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT
  } state_e;

  // Store access request from the sequencer
  typedef struct packed {
    logic              we_a;
    logic              we_b;
    logic [ADDR_W-1:0] waddr;
    logic              re;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
  } mem_req_t;

  // Tag that follows one multiply-accumulate step down the pipeline
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic             end_run;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } mac_tag_t;

  // Dimension register as used: zero reads as one, large values as MAX_DIM
  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] r;
    r = v;
    if (v == '0) r = CFG_W'(1);
    else if (32'(v) > MAX_DIM) r = CFG_W'(MAX_DIM);
    return r;
  endfunction

  // Highest index for a dimension register value
  function automatic logic [IDX_W-1:0] last_idx(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] c;
    c = clamp_dim(v) - CFG_W'(1);
    return c[IDX_W-1:0];
  endfunction

  // Row-major store address
  function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] row,
                                                input logic [IDX_W-1:0] col);
    logic [ADDR_W+IDX_W-1:0] a;
    a = (ADDR_W+IDX_W)'(row) * (ADDR_W+IDX_W)'(MAX_DIM) + (ADDR_W+IDX_W)'(col);
    return a[ADDR_W-1:0];
  endfunction

endpackage

FILE: rtl/imm_ram.sv
// Simple dual-port synchronous RAM with registered read.
`timescale 1ns / 1ps
module imm_ram #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds its word when idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/imm_ctrl.sv
// Sequencer: configuration registers, element writes and read address order.
`timescale 1ns / 1ps
module imm_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // item side
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [imm_pkg::MODE_W-1:0]   in_mode_i,
  input  logic [imm_pkg::IDX_W-1:0]    in_row_i,
  input  logic [imm_pkg::IDX_W-1:0]    in_col_i,
  // configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [imm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [imm_pkg::CFG_W-1:0]    cfg_data_i,
  // store requests and pipeline tag
  output imm_pkg::mem_req_t            mem_req_o,
  output imm_pkg::mac_tag_t            tag_o,
  input  logic                         moved_i
);
  import imm_pkg::*;

  state_e           state_q, state_d;
  logic [CFG_W-1:0] rows_q, rows_d;
  logic [CFG_W-1:0] inner_q, inner_d;
  logic [CFG_W-1:0] cols_q, cols_d;
  logic [IDX_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic [IDX_W-1:0] last_i_q, last_i_d, last_j_q, last_j_d, last_k_q, last_k_d;

  logic  accept;
  logic  start;
  logic  k_end;
  logic  end_run;
  logic  in_range;
  mode_e mode;

  assign mode        = mode_e'(in_mode_i);
  assign cfg_ready_o = 1'b1;
  assign k_end       = (k_q == last_k_q);
  assign end_run     = (i_q == last_i_q) && (j_q == last_j_q);
  assign in_range    = (32'(in_row_i) < MAX_DIM) && (32'(in_col_i) < MAX_DIM);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start) state_d = ST_RUN;
      ST_RUN:  if (k_end) state_d = ST_WAIT;
      ST_WAIT: if (moved_i) state_d = end_run ? ST_IDLE : ST_RUN;
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs: handshake, store requests, tag
  always_comb begin
    in_ready_o        = (state_q == ST_IDLE);
    accept            = in_valid_i && in_ready_o;
    start             = accept && (mode == MODE_COMPUTE);
    mem_req_o.we_a    = accept && (mode == MODE_WRITE_A) && in_range;
    mem_req_o.we_b    = accept && (mode == MODE_WRITE_B) && in_range;
    mem_req_o.waddr   = addr_of(in_row_i, in_col_i);
    mem_req_o.re      = (state_q == ST_RUN);
    mem_req_o.raddr_a = addr_of(i_q, k_q);
    mem_req_o.raddr_b = addr_of(k_q, j_q);
    tag_o.valid       = (state_q == ST_RUN);
    tag_o.first       = (k_q == '0);
    tag_o.last        = k_end;
    tag_o.end_run     = end_run;
    tag_o.row         = i_q;
    tag_o.col         = j_q;
  end

  // Configuration decode
  always_comb begin
    rows_d  = rows_q;
    inner_d = inner_q;
    cols_d  = cols_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_ROWS_A:    rows_d  = cfg_data_i;
        REG_INNER_DIM: inner_d = cfg_data_i;
        REG_COLS_B:    cols_d  = cfg_data_i;
        default: ;
      endcase
    end
  end

  // Loop counters: k innermost, then column, then row
  always_comb begin
    i_d      = i_q;
    j_d      = j_q;
    k_d      = k_q;
    last_i_d = last_i_q;
    last_j_d = last_j_q;
    last_k_d = last_k_q;
    if (start) begin
      i_d      = '0;
      j_d      = '0;
      k_d      = '0;
      last_i_d = last_idx(rows_q);
      last_j_d = last_idx(cols_q);
      last_k_d = last_idx(inner_q);
    end else if (state_q == ST_RUN && !k_end) begin
      k_d = IDX_W'(k_q + 1'b1);
    end else if (state_q == ST_WAIT && moved_i && !end_run) begin
      k_d = '0;
      if (j_q == last_j_q) begin
        j_d = '0;
        i_d = IDX_W'(i_q + 1'b1);
      end else begin
        j_d = IDX_W'(j_q + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rows_q   <= CFG_W'(MAX_DIM);
      inner_q  <= CFG_W'(MAX_DIM);
      cols_q   <= CFG_W'(MAX_DIM);
      i_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
      last_i_q <= '0;
      last_j_q <= '0;
      last_k_q <= '0;
    end else begin
      state_q  <= state_d;
      rows_q   <= rows_d;
      inner_q  <= inner_d;
      cols_q   <= cols_d;
      i_q      <= i_d;
      j_q      <= j_d;
      k_q      <= k_d;
      last_i_q <= last_i_d;
      last_j_q <= last_j_d;
      last_k_q <= last_k_d;
    end
  end

endmodule

FILE: rtl/imm_mac.sv
// Multiply-accumulate pipeline and output word register.
`timescale 1ns / 1ps
module imm_mac (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  imm_pkg::mac_tag_t             tag_i,
  input  logic [imm_pkg::DATA_W-1:0]    a_rdata_i,
  input  logic [imm_pkg::DATA_W-1:0]    b_rdata_i,
  output logic                          moved_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [imm_pkg::M_TDATA_W-1:0] out_data_o,
  output logic                          out_last_o
);
  import imm_pkg::*;

  mac_tag_t          s1_q, s2_q;
  logic [DATA_W-1:0] prod_q, prod_d;
  logic [DATA_W-1:0] acc_q, acc_d;
  logic              pend_q, pend_d;
  logic              pend_last_q;
  logic [IDX_W-1:0]  pend_row_q, pend_col_q;
  logic              out_valid_q, out_valid_d;
  logic [M_TDATA_W-1:0] out_data_q;
  logic              out_last_q;

  // Product keeps the low word only; sums wrap
  assign prod_d  = DATA_W'(a_rdata_i * b_rdata_i);
  assign acc_d   = s2_q.first ? prod_q : DATA_W'(acc_q + prod_q);
  // Finished sum goes to the output register once that is free
  assign moved_o = pend_q && (!out_valid_q || out_ready_i);

  always_comb begin
    pend_d = pend_q;
    if (moved_o) pend_d = 1'b0;
    if (s2_q.valid && s2_q.last) pend_d = 1'b1;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (moved_o) out_valid_d = 1'b1;
  end

  // Control state of the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q        <= '0;
      s2_q        <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_q        <= tag_i;
      s2_q        <= s1_q;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Data path registers
  always_ff @(posedge clk_i) begin
    if (s1_q.valid) begin
      prod_q <= prod_d;
    end
    if (s2_q.valid) begin
      acc_q <= acc_d;
      if (s2_q.last) begin
        pend_last_q <= s2_q.end_run;
        pend_row_q  <= s2_q.row;
        pend_col_q  <= s2_q.col;
      end
    end
    if (moved_o) begin
      out_data_q <= {{PAD_W{1'b0}}, acc_q, pend_col_q, pend_row_q};
      out_last_q <= pend_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

endmodule

FILE: rtl/integer_matrix_multiply_unit.sv
// Integer matrix multiply unit: top level with the A and B element stores.
`timescale 1ns / 1ps
// C = A x B on signed 32-bit elements held in two 64-word stores, sums
// wrapping to 32 bits. An input word with tuser 0 or 1 writes one element
// of A or B; tuser 2 starts a product, which streams every element of C
// in row-major order with tlast on the final one. Each result element is
// built from one store read and multiply-accumulate per cycle through the
// single read port of each store, then a three-stage drain (read,
// multiply, add) before the sum is handed to the output register. New
// items are taken only while no product is in progress; the last result
// may still wait in the output register. Dimension registers are sampled
// when a product starts, zero counting as one and values above eight as
// eight.
module integer_matrix_multiply_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: row_index[2:0], col_index[5:3], element_value[37:6], zero pad
  input  logic [imm_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // tuser: mode[1:0]
  input  logic [imm_pkg::MODE_W-1:0]     s_axis_tuser,
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: out_row[2:0], out_col[5:3], product_value[37:6], zero pad
  output logic [imm_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  output logic                           m_axis_tlast,
  // configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [imm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [imm_pkg::CFG_W-1:0]      cfg_data_i
);
  import imm_pkg::*;

`include "assert_macros.svh"

  mem_req_t          mem_req;
  mac_tag_t          tag;
  logic              moved;
  logic [IDX_W-1:0]  in_row, in_col;
  logic [DATA_W-1:0] in_value;
  logic [DATA_W-1:0] a_rdata, b_rdata;

  // Unpack the input word
  assign in_row   = s_axis_tdata[IDX_W-1:0];
  assign in_col   = s_axis_tdata[2*IDX_W-1:IDX_W];
  assign in_value = s_axis_tdata[FIELD_W-1:2*IDX_W];

  imm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_mode_i   (s_axis_tuser),
    .in_row_i    (in_row),
    .in_col_i    (in_col),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .mem_req_o   (mem_req),
    .tag_o       (tag),
    .moved_i     (moved)
  );

  // Element stores
  imm_ram #(.DEPTH(DEPTH), .WIDTH(DATA_W), .ADDR_W(ADDR_W)) u_store_a (
    .clk_i   (clk_i),
    .we_i    (mem_req.we_a),
    .waddr_i (mem_req.waddr),
    .wdata_i (in_value),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr_a),
    .rdata_o (a_rdata)
  );

  imm_ram #(.DEPTH(DEPTH), .WIDTH(DATA_W), .ADDR_W(ADDR_W)) u_store_b (
    .clk_i   (clk_i),
    .we_i    (mem_req.we_b),
    .waddr_i (mem_req.waddr),
    .wdata_i (in_value),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr_b),
    .rdata_o (b_rdata)
  );

  imm_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tag_i       (tag),
    .a_rdata_i   (a_rdata),
    .b_rdata_i   (b_rdata),
    .moved_o     (moved),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

  // Writes are taken only while no product reads the stores
  `ASSERT_NEVER(a_write_during_read, s_axis_tready && mem_req.re,
                "store write accepted while a product is reading")
  // A finished sum never overwrites a result still waiting at the output
  `ASSERT_CLK(a_no_overwrite, moved |-> (!m_axis_tvalid || m_axis_tready),
              "result register overwritten before it was taken")
  // A product request starts reading the stores in the next cycle
  `ASSERT_CLK(a_start_reads,
              (s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_COMPUTE))
                |=> mem_req.re,
              "product request did not start store reads")

endmodule

FILE: dv/integer_matrix_multiply_unit_test.sv
// Self-checking stream testbench of the integer matrix multiply unit.
`timescale 1ns / 1ps
module integer_matrix_multiply_unit_test;
  import imm_pkg::*;

  // Codes without a package name
  localparam logic [MODE_W-1:0]    MODE_NONE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam int ITEM_TARGET = 330;
  localparam int SETTLE_CYC  = 24;
  localparam int HOLD_CYC    = 300;
  localparam int IDLE_LIMIT  = 4000;

  // One input word: element write or product request
  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [DATA_W-1:0] value;
  } elem_cmd_t;

  // One element of the product C
  typedef struct {
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [DATA_W-1:0] value;
    logic              last;
  } c_elem_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic [MODE_W-1:0]    s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [CFG_W-1:0]     cfg_data_i    = '0;

  elem_cmd_t cmd_q[$];
  c_elem_t   c_elem_q[$];

  // Predicted stores and dimension registers
  logic [DATA_W-1:0] mat_a [DEPTH];
  logic [DATA_W-1:0] mat_b [DEPTH];
  logic [CFG_W-1:0]  dim_rows  = CFG_W'(8);
  logic [CFG_W-1:0]  dim_inner = CFG_W'(8);
  logic [CFG_W-1:0]  dim_cols  = CFG_W'(8);

  // Entries written so far, so that a product never reads a blank one
  bit a_set [DEPTH];
  bit b_set [DEPTH];

  int      item_cnt   = 0;
  int      mismatches = 0;
  int      idle_cyc   = 0;
  int      tx_gap     = 0;
  int      tx_burst   = 0;
  bit      tx_gaps_on = 1'b0;
  bit      tx_fire;
  int      rx_mode    = 0;
  bit      hold_req   = 1'b0;
  int      hold_left  = 0;
  logic [15:0] stall_pat = 16'b1011_0110_1110_0101;
  c_elem_t rx_got;
  c_elem_t rx_want;

  integer_matrix_multiply_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Dimension as used: zero counts as one, above MAX_DIM as MAX_DIM
  function automatic int used_dim(input logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  // Update the predicted stores, or queue the elements of C
  task automatic matmul_predict(input elem_cmd_t cmd);
    int nr, nk, nc;
    logic [DATA_W-1:0] acc;
    c_elem_t e;
    nr = used_dim(dim_rows);
    nk = used_dim(dim_inner);
    nc = used_dim(dim_cols);
    case (cmd.mode)
      MODE_WRITE_A: mat_a[int'(cmd.row) * MAX_DIM + int'(cmd.col)] = cmd.value;
      MODE_WRITE_B: mat_b[int'(cmd.row) * MAX_DIM + int'(cmd.col)] = cmd.value;
      MODE_COMPUTE: begin
        for (int i = 0; i < nr; i++) begin
          for (int j = 0; j < nc; j++) begin
            acc = '0;
            for (int k = 0; k < nk; k++) begin
              acc += mat_a[i * MAX_DIM + k] * mat_b[k * MAX_DIM + j];
            end
            e.row   = IDX_W'(i);
            e.col   = IDX_W'(j);
            e.value = acc;
            e.last  = (i == nr - 1) && (j == nc - 1);
            c_elem_q.push_back(e);
          end
        end
      end
      default: ;
    endcase
  endtask

  // Element values weighted toward the extremes
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return '1;
      4: return DATA_W'($urandom_range(0, 15) - 8);
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // Dimension register values: mostly small, with zero and the top end
  function automatic logic [CFG_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CFG_W'(8);
      2: return CFG_W'($urandom_range(9, 15));
      default: return CFG_W'($urandom_range(1, 4));
    endcase
  endfunction

  task automatic queue_cmd(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] row,
                           input logic [IDX_W-1:0] col, input logic [DATA_W-1:0] value);
    elem_cmd_t cmd;
    cmd.mode  = mode;
    cmd.row   = row;
    cmd.col   = col;
    cmd.value = value;
    if (mode == MODE_WRITE_A) a_set[int'(row) * MAX_DIM + int'(col)] = 1'b1;
    if (mode == MODE_WRITE_B) b_set[int'(row) * MAX_DIM + int'(col)] = 1'b1;
    cmd_q.push_back(cmd);
    item_cnt++;
  endtask

  // Random element write, half of them inside the current dimensions
  task automatic queue_rand_write();
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0] row, col;
    mode = $urandom_range(0, 1) ? MODE_WRITE_B : MODE_WRITE_A;
    if ($urandom_range(0, 1)) begin
      row = IDX_W'($urandom);
      col = IDX_W'($urandom);
    end else if (mode == MODE_WRITE_A) begin
      row = IDX_W'($urandom_range(0, used_dim(dim_rows) - 1));
      col = IDX_W'($urandom_range(0, used_dim(dim_inner) - 1));
    end else begin
      row = IDX_W'($urandom_range(0, used_dim(dim_inner) - 1));
      col = IDX_W'($urandom_range(0, used_dim(dim_cols) - 1));
    end
    queue_cmd(mode, row, col, pick_value());
  endtask

  // Product request, preceded by writes of any entry it reads still blank
  task automatic queue_compute();
    int nr, nk, nc;
    nr = used_dim(dim_rows);
    nk = used_dim(dim_inner);
    nc = used_dim(dim_cols);
    for (int i = 0; i < nr; i++)
      for (int k = 0; k < nk; k++)
        if (!a_set[i * MAX_DIM + k])
          queue_cmd(MODE_WRITE_A, IDX_W'(i), IDX_W'(k), pick_value());
    for (int k = 0; k < nk; k++)
      for (int j = 0; j < nc; j++)
        if (!b_set[k * MAX_DIM + j])
          queue_cmd(MODE_WRITE_B, IDX_W'(k), IDX_W'(j), pick_value());
    queue_cmd(MODE_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), DATA_W'($urandom));
  endtask

  // Register write over the configuration channel
  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_ROWS_A:    dim_rows  = data;
      REG_INNER_DIM: dim_inner = data;
      REG_COLS_B:    dim_cols  = data;
      default: ;
    endcase
  endtask

  task automatic set_dims(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] k,
                          input logic [CFG_W-1:0] c);
    write_cfg(REG_ROWS_A, r);
    write_cfg(REG_INNER_DIM, k);
    write_cfg(REG_COLS_B, c);
  endtask

  // Wait until every word is sent and every product word has come back
  task automatic settle();
    while (cmd_q.size() != 0 || s_axis_tvalid || c_elem_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // Driver: bursts of words with random gaps, valid held until accepted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      tx_fire = s_axis_tvalid && s_axis_tready;
      if (tx_fire) matmul_predict(cmd_q.pop_front());
      if (!s_axis_tvalid || tx_fire) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (cmd_q.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= S_TDATA_W'({cmd_q[0].value, cmd_q[0].col, cmd_q[0].row});
          s_axis_tuser  <= cmd_q[0].mode;
          if (tx_burst > 0) begin
            tx_burst--;
          end else begin
            tx_burst = $urandom_range(1, 12);
            if (tx_gaps_on) tx_gap = $urandom_range(1, 6);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each product word, then pick the next ready
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        rx_got.row   = m_axis_tdata[IDX_W-1:0];
        rx_got.col   = m_axis_tdata[2*IDX_W-1:IDX_W];
        rx_got.value = m_axis_tdata[2*IDX_W +: DATA_W];
        rx_got.last  = m_axis_tlast;
        if (c_elem_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected product word: row %0d col %0d value %h last %b",
                     rx_got.row, rx_got.col, rx_got.value, rx_got.last);
        end else begin
          rx_want = c_elem_q.pop_front();
          if (rx_got.row !== rx_want.row || rx_got.col !== rx_want.col ||
              rx_got.value !== rx_want.value || rx_got.last !== rx_want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"product word wrong: want row %0d col %0d value %h last %b,",
                        " got row %0d col %0d value %h last %b"},
                       rx_want.row, rx_want.col, rx_want.value, rx_want.last,
                       rx_got.row, rx_got.col, rx_got.value, rx_got.last);
          end
        end
      end
      // long hold-off, requested once by the stimulus
      if (hold_req) begin
        hold_left = HOLD_CYC;
        hold_req  = 1'b0;
      end
      stall_pat <= {stall_pat[14:0], stall_pat[15]};
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 3) != 0);
          2: m_axis_tready <= stall_pat[15];
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Watchdog on cycles with no word moved anywhere
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cyc <= 0;
      end else if (idle_cyc >= IDLE_LIMIT) begin
        $display("integer_matrix_multiply_unit: mismatch");
        $finish;
      end else begin
        idle_cyc <= idle_cyc + 1;
      end
    end
  end

  // Stimulus
  initial begin
    int n;
    int pick;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 1x1x1 from zero registers: extreme products, unused mode, far writes
    rx_mode    = 0;
    tx_gaps_on = 1'b0;
    set_dims('0, '0, '0);
    queue_cmd(MODE_WRITE_A, '0, '0, 32'h8000_0000);
    queue_cmd(MODE_WRITE_B, '0, '0, 32'h8000_0000);
    queue_compute();
    queue_cmd(MODE_NONE, '1, '1, '1);
    queue_cmd(MODE_WRITE_A, '0, '0, 32'h7fff_ffff);
    queue_cmd(MODE_WRITE_B, '0, '0, 32'h7fff_ffff);
    queue_compute();
    queue_cmd(MODE_WRITE_A, '1, '1, '1);
    queue_cmd(MODE_WRITE_B, '1, '1, '0);
    queue_cmd(MODE_WRITE_A, '0, '0, '1);
    queue_compute();
    settle();

    // rows clamped from above, spare register index, overwrite and redo
    rx_mode    = 2;
    tx_gaps_on = 1'b1;
    set_dims(CFG_W'(15), CFG_W'(1), CFG_W'(2));
    write_cfg(REG_SPARE, '1);
    queue_compute();
    queue_cmd(MODE_WRITE_B, '0, IDX_W'(1), 32'h0000_0001);
    queue_compute();
    settle();

    // back-to-back products against a long output hold-off
    rx_mode    = 1;
    tx_gaps_on = 1'b0;
    set_dims(CFG_W'(3), CFG_W'(2), CFG_W'(3));
    repeat (4) queue_compute();
    repeat (6) queue_rand_write();
    queue_compute();
    hold_req = 1'b1;
    settle();

    // random phases, each with its own dimensions and pacing
    while (item_cnt < ITEM_TARGET) begin
      set_dims(pick_dim(), pick_dim(), pick_dim());
      if ($urandom_range(0, 5) == 0) write_cfg(REG_SPARE, CFG_W'($urandom));
      rx_mode    = $urandom_range(0, 3);
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      n = $urandom_range(8, 30);
      repeat (n) begin
        pick = $urandom_range(0, 99);
        if (pick < 6) queue_cmd(MODE_NONE, IDX_W'($urandom), IDX_W'($urandom), pick_value());
        else if (pick < 22) queue_compute();
        else queue_rand_write();
      end
      queue_compute();
      settle();
    end

    if (mismatches == 0) begin
      $display("integer_matrix_multiply_unit: match");
    end else begin
      $display("integer_matrix_multiply_unit: mismatch");
    end
    $finish;
  end

endmodule
